// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// All checks are sampled on the rising edge of i_clk.
// SSWS_ASSERT checks are muted while i_rst_n is low; SSWS_ASSERT_ALWAYS checks are not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while the block is out of reset.
`define SSWS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define SSWS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/sswsum_pkg.sv
`timescale 1ns / 1ps

package sswsum_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int SUM_W        = 40;
    localparam int INDEX_W      = 32;
    localparam int LEN_REG_W    = 9;
    localparam int STEP_W       = 16;
    localparam int CFG_DATA_W   = 16;

    typedef enum logic [0:0] {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_WINDOW_STEP   = 1'b1
    } t_cfg_index;

    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           first;
    } t_sample_req;

    typedef struct packed {
        logic signed [SUM_W-1:0] window_sum;
        logic [INDEX_W-1:0]      window_index;
    } t_window_req;

endpackage

// File: hw/rtl/sswsum_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read, read-before-write on a shared address.
module sswsum_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/strided_sliding_window_sum.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Dir  Handshake                  Payload
// in        in   i_in_valid / o_in_ready    i_in  (sswsum_pkg::t_sample_req)
// out       out  o_out_valid / i_out_ready  o_out (sswsum_pkg::t_window_req)
// cfg       in   i_cfg_wr_en                i_cfg_index, i_cfg_wdata
//
// One request per clock sustained while the input is not stalled; a result passes
// from the sum stage register into the output register. The delay-store RAM read
// is issued at acceptance and its registered data is consumed by the sum stage.
// Reset (synchronous, active low) clears the sum, counters, pointer and sets
// length and step to 1. The delay store is not cleared.
// Input stalls only when the sum stage holds a window result and the output
// register is full and not being taken.
module strided_sliding_window_sum #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  sswsum_pkg::t_cfg_index              i_cfg_index,
    input  logic [sswsum_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // sample stream
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sswsum_pkg::t_sample_req             i_in,
    // window results
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sswsum_pkg::t_window_req             o_out
);

    import sswsum_pkg::*;

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);   // holds MAX_WINDOW itself
    localparam int ADDR_W = LEN_W + 1;                // room for wp + MAX_WINDOW

    // ---------------- configuration (stored as effective values) ----------------
    logic [LEN_W-1:0]     r_len;
    logic [STEP_W-1:0]    r_step;
    logic [LEN_REG_W-1:0] cfg_len_raw;

    assign cfg_len_raw = i_cfg_wdata[LEN_REG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_W'(1);
            r_step <= STEP_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_WINDOW_LENGTH: begin
                    // zero acts as one, anything above the store depth is clamped
                    if (cfg_len_raw == '0) begin
                        r_len <= LEN_W'(1);
                    end else if (int'(cfg_len_raw) > MAX_WINDOW) begin
                        r_len <= LEN_W'(MAX_WINDOW);
                    end else begin
                        r_len <= LEN_W'(cfg_len_raw);
                    end
                end
                CFG_WINDOW_STEP: begin
                    r_step <= (i_cfg_wdata[STEP_W-1:0] == '0) ? STEP_W'(1)
                                                              : i_cfg_wdata[STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- front end: store write and old-sample read ----------------
    logic              in_accept;
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  waddr;
    logic [PTR_W-1:0]  n_wp;
    logic [ADDR_W-1:0] wext;
    logic [ADDR_W-1:0] lext;
    logic [ADDR_W-1:0] rfull;
    logic [PTR_W-1:0]  raddr;
    logic [SAMPLE_WIDTH-1:0] ram_rdata;

    assign in_accept = i_in_valid && o_in_ready;

    // a sequence start restarts the circular pointer at slot 0
    assign waddr = i_in.first ? '0 : r_wp;
    assign n_wp  = (waddr == PTR_W'(MAX_WINDOW - 1)) ? '0 : waddr + PTR_W'(1);

    // slot leaving the window: length samples back, modulo the store depth
    assign wext  = ADDR_W'(waddr);
    assign lext  = ADDR_W'(r_len);
    assign rfull = (wext >= lext) ? wext - lext : wext + ADDR_W'(MAX_WINDOW) - lext;
    assign raddr = rfull[PTR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (in_accept) begin
            r_wp <= n_wp;
        end
    end

    // read-before-write covers length == depth, where both addresses match
    sswsum_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_WINDOW)
    ) u_delay_store (
        .i_clk   (i_clk),
        .i_we    (in_accept),
        .i_waddr (waddr),
        .i_wdata (i_in.sample),
        .i_re    (in_accept),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------- sum stage ----------------
    logic                           r_v1;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                           r_first;

    t_sum               r_sum;
    logic [LEN_W-1:0]   r_fill;
    logic [STEP_W-1:0]  r_stride;
    logic [INDEX_W-1:0] r_wcnt;

    t_sum               sum0, n_sum, leave;
    logic [LEN_W-1:0]   fill0, n_fill;
    logic [STEP_W-1:0]  stride0, n_stride;
    logic [INDEX_W-1:0] wcnt0, n_wcnt;
    logic               full;
    logic               emit;
    logic               s1_adv;

    always_comb begin
        sum0    = r_first ? '0 : r_sum;
        fill0   = r_first ? '0 : r_fill;
        stride0 = r_first ? '0 : r_stride;
        wcnt0   = r_first ? '0 : r_wcnt;

        full  = (fill0 >= r_len);
        leave = full ? SUM_W'($signed(ram_rdata)) : '0;
        n_sum = sum0 + SUM_W'(r_sample) - leave;

        emit     = 1'b0;
        n_fill   = fill0;
        n_stride = stride0;
        if (!full) begin
            // still filling the first window
            n_fill = fill0 + LEN_W'(1);
            if (n_fill >= r_len) begin
                emit     = 1'b1;
                n_stride = '0;
            end
        end else begin
            n_stride = stride0 + STEP_W'(1);
            if (n_stride >= r_step) begin
                emit     = 1'b1;
                n_stride = '0;
            end
        end

        n_wcnt = emit ? wcnt0 + INDEX_W'(1) : wcnt0;
    end

    // stage holds only when it has a result and the output register can't take it
    assign s1_adv     = r_v1 && (!emit || !o_out_valid || i_out_ready);
    assign o_in_ready = !r_v1 || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_sum    <= '0;
            r_fill   <= '0;
            r_stride <= '0;
            r_wcnt   <= '0;
        end else begin
            if (in_accept) begin
                r_v1 <= 1'b1;
            end else if (s1_adv) begin
                r_v1 <= 1'b0;
            end
            if (s1_adv) begin
                r_sum    <= n_sum;
                r_fill   <= n_fill;
                r_stride <= n_stride;
                r_wcnt   <= n_wcnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sample <= i_in.sample;
            r_first  <= i_in.first;
        end
    end

    // ---------------- output register ----------------
    logic        r_out_valid;
    t_window_req r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && emit) begin
            r_out.window_sum   <= n_sum;
            r_out.window_index <= wcnt0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------- checks ----------------
    `SSWS_ASSERT(a_stall_cause, (r_v1 && !s1_adv) |-> (r_out_valid && !i_out_ready),
                 "sum stage stalled without a blocked output")
    `SSWS_ASSERT(a_first_index, (s1_adv && emit && r_first) |=> (o_out.window_index == '0),
                 "first window of a sequence not numbered zero")
    `SSWS_ASSERT(a_fill_range, r_fill <= LEN_W'(MAX_WINDOW),
                 "fill count beyond store depth")
    `SSWS_ASSERT(a_wp_range, r_wp <= PTR_W'(MAX_WINDOW - 1),
                 "write pointer beyond store depth")

endmodule
